### src/risp_pkg.sv
// Shared types, codes and constants for the resource index stream parser.
package risp_pkg;

  localparam int ROW_W     = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int SUB_W     = 6;
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = 3;
  localparam int RES_CNT_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_LOADED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCHIVE_BASE = 2'd1;

  // Header layout
  localparam logic [31:0]      MAGIC_WORD    = 32'h0553_4552;
  localparam logic [SUB_W-1:0] HDR_MAGIC_END = 6'd4;
  localparam logic [SUB_W-1:0] HDR_DECL_END  = 6'd8;
  localparam logic [SUB_W-1:0] HDR_COUNT_POS = 6'd32;
  localparam logic [SUB_W-1:0] HDR_LEN       = 6'd36;

  // Row layout
  localparam logic [SUB_W-1:0] WORD_BYTES     = 6'd4;
  localparam logic [SUB_W-1:0] TRL_OFF_END    = 6'd8;
  localparam logic [SUB_W-1:0] TRL_SIZE_END   = 6'd12;
  localparam logic [SUB_W-1:0] TRL_STORED_END = 6'd16;
  localparam logic [SUB_W-1:0] TRL_FLAG_POS   = 6'd20;

  localparam logic [31:0] LEN_BIAS = 32'h20;
  localparam logic [7:0]  CHAR_LO  = 8'h20;
  localparam logic [7:0]  CHAR_HI  = 8'h7e;
  localparam logic [1:0]  FIELD_COUNT = 2'd3;

  typedef enum logic [2:0] {
    KIND_CHAR      = 3'd0,
    KIND_FIELD_END = 3'd1,
    KIND_ROW       = 3'd2,
    KIND_ACCEPT    = 3'd3,
    KIND_REJECT    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REJ_MAGIC      = 3'd0,
    REJ_ROW_LIMIT  = 3'd1,
    REJ_FIELD_LONG = 3'd2,
    REJ_BAD_CHAR   = 3'd3,
    REJ_EMPTY_TYPE = 3'd4,
    REJ_FLAG       = 3'd5,
    REJ_TRUNCATED  = 3'd6,
    REJ_LENGTH     = 3'd7
  } rej_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ORDINAL = 3'd1,
    PH_LEN     = 3'd2,
    PH_CHARS   = 3'd3,
    PH_TRAILER = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef struct packed {
    kind_t            kind;
    logic [1:0]       field_id;
    logic [6:0]       char_value;
    logic [ROW_W-1:0] row_number;
    logic [63:0]      row_offset;
    logic [31:0]      row_size;
    logic [31:0]      row_stored_size;
    logic [1:0]       row_archive;
    rej_t             reject_code;
    logic             final_res;
  } res_t;

  // Up to two results come out of one byte
  typedef struct packed {
    logic v0;
    logic v1;
    res_t res0;
    res_t res1;
  } res_push_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = MAGIC_WORD[31:24];
      2'd1:    b = MAGIC_WORD[23:16];
      2'd2:    b = MAGIC_WORD[15:8];
      default: b = MAGIC_WORD[7:0];
    endcase
    return b;
  endfunction

  function automatic res_t res_text(input kind_t k, input logic [1:0] fid,
                                    input logic [6:0] ch, input logic [ROW_W-1:0] row);
    res_t r;
    r            = '0;
    r.kind       = k;
    r.field_id   = fid;
    r.char_value = ch;
    r.row_number = row;
    return r;
  endfunction

  function automatic res_t res_end(input kind_t k, input rej_t code, input logic fin);
    res_t r;
    r             = '0;
    r.kind        = k;
    r.reject_code = (k == KIND_REJECT) ? code : REJ_MAGIC;
    r.final_res   = fin;
    return r;
  endfunction

endpackage

### src/risp_parser.sv
// Byte input register and the single-pass parse step that updates state and forms results.
module risp_parser
  import risp_pkg::*;
#(
  parameter int FIELD_LIMIT = 4096,
  parameter int ROW_LIMIT   = 1000000,
  parameter int FILE_LIMIT  = 67108864
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_take,
  input  logic [7:0]       in_byte,
  input  logic             in_eof,
  input  logic [ROW_W-1:0] rows_loaded,
  input  logic [1:0]       archive_base,
  output logic             stg_busy,
  output res_push_t        push
);

  localparam int SEEN_W = $clog2(FILE_LIMIT + 2);
  localparam int FLEN_W = $clog2(FIELD_LIMIT);
  localparam logic [SEEN_W-1:0] FILE_LIM  = SEEN_W'(FILE_LIMIT);
  localparam logic [ROW_W-1:0]  ROW_LIM   = ROW_W'(ROW_LIMIT);
  localparam logic [31:0]       FIELD_LIM = 32'(FIELD_LIMIT);

  // byte register
  logic       stg_v_r;
  logic [7:0] stg_byte_r;
  logic       stg_eof_r;

  // parse state
  phase_t            phase_r, phase_nxt;
  logic [SUB_W-1:0]  sub_r, sub_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [31:0]       decl_r, decl_nxt;
  logic [ROW_W-1:0]  rows_left_r, rows_left_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [FLEN_W-1:0] left_r, left_nxt;
  logic [1:0]        fsel_r, fsel_nxt;
  logic [63:0]       asm_r, asm_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [31:0]       stored_r, stored_nxt;
  logic              failed_r, failed_nxt;

  logic [ROW_W-1:0]  room;
  logic              fail;
  rej_t              fail_code;
  logic              do_next;
  logic              clear;
  logic              mv0, mv1;
  res_t              m0, m1;
  res_t              fin_res;
  logic [31:0]       word;
  logic [6:0]        ch;

  assign room     = (rows_loaded >= ROW_LIM) ? '0 : ROW_LIM - rows_loaded;
  assign stg_busy = stg_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_byte_r <= in_byte;
      stg_eof_r  <= in_eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      sub_r       <= '0;
      seen_r      <= '0;
      decl_r      <= '0;
      rows_left_r <= '0;
      cur_row_r   <= '0;
      left_r      <= '0;
      fsel_r      <= '0;
      asm_r       <= '0;
      size_r      <= '0;
      stored_r    <= '0;
      failed_r    <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sub_r       <= sub_nxt;
      seen_r      <= seen_nxt;
      decl_r      <= decl_nxt;
      rows_left_r <= rows_left_nxt;
      cur_row_r   <= cur_row_nxt;
      left_r      <= left_nxt;
      fsel_r      <= fsel_nxt;
      asm_r       <= asm_nxt;
      size_r      <= size_nxt;
      stored_r    <= stored_nxt;
      failed_r    <= failed_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    sub_nxt       = sub_r;
    seen_nxt      = seen_r;
    decl_nxt      = decl_r;
    rows_left_nxt = rows_left_r;
    cur_row_nxt   = cur_row_r;
    left_nxt      = left_r;
    fsel_nxt      = fsel_r;
    asm_nxt       = asm_r;
    size_nxt      = size_r;
    stored_nxt    = stored_r;
    failed_nxt    = failed_r;
    fail          = 1'b0;
    fail_code     = REJ_MAGIC;
    do_next       = 1'b0;
    clear         = 1'b0;
    mv0           = 1'b0;
    mv1           = 1'b0;
    m0            = '0;
    m1            = '0;
    fin_res       = '0;
    word          = '0;
    ch            = stg_byte_r[6:0];
    push          = '0;

    if (stg_v_r) begin
      if (failed_r) begin
        // skip to the end of the file
        clear = stg_eof_r;
      end else begin
        if (seen_r <= FILE_LIM) begin
          seen_nxt = seen_r + SEEN_W'(1);
        end
        if (seen_nxt > FILE_LIM) begin
          fail      = 1'b1;
          fail_code = REJ_LENGTH;
        end else begin
          case (phase_r)
            PH_HEADER: begin
              if (sub_r < HDR_MAGIC_END) begin
                if (stg_byte_r != magic_byte(sub_r[1:0])) begin
                  fail      = 1'b1;
                  fail_code = REJ_MAGIC;
                end
              end else if (sub_r < HDR_DECL_END) begin
                decl_nxt = {decl_r[23:0], stg_byte_r};
              end else if (sub_r >= HDR_COUNT_POS) begin
                asm_nxt = {32'h0, asm_r[23:0], stg_byte_r};
              end
              if (!fail) begin
                sub_nxt = sub_r + SUB_W'(1);
                if (sub_nxt == HDR_LEN) begin
                  word = asm_nxt[31:0];
                  if (word > {12'h0, room}) begin
                    fail      = 1'b1;
                    fail_code = REJ_ROW_LIMIT;
                  end else begin
                    rows_left_nxt = word[ROW_W-1:0];
                    cur_row_nxt   = '0;
                    sub_nxt       = '0;
                    asm_nxt       = '0;
                    phase_nxt     = (word[ROW_W-1:0] != '0) ? PH_ORDINAL : PH_DONE;
                  end
                end
              end
            end
            PH_ORDINAL: begin
              sub_nxt = sub_r + SUB_W'(1);
              if (sub_nxt >= WORD_BYTES) begin
                phase_nxt = PH_LEN;
                sub_nxt   = '0;
                asm_nxt   = '0;
                fsel_nxt  = '0;
              end
            end
            PH_LEN: begin
              word = asm_r[31:0];
              case (sub_r[1:0])
                2'd0:    word[7:0]   = stg_byte_r;
                2'd1:    word[15:8]  = stg_byte_r;
                2'd2:    word[23:16] = stg_byte_r;
                default: word[31:24] = stg_byte_r;
              endcase
              asm_nxt = {32'h0, word};
              sub_nxt = sub_r + SUB_W'(1);
              if (sub_nxt >= WORD_BYTES) begin
                if (word >= FIELD_LIM) begin
                  fail      = 1'b1;
                  fail_code = REJ_FIELD_LONG;
                end else if (fsel_r == 2'd0 && word == '0) begin
                  fail      = 1'b1;
                  fail_code = REJ_EMPTY_TYPE;
                end else begin
                  left_nxt = word[FLEN_W-1:0];
                  if (word == '0) begin
                    do_next = 1'b1;
                  end else begin
                    phase_nxt = PH_CHARS;
                  end
                end
              end
            end
            PH_CHARS: begin
              if (stg_byte_r < CHAR_LO || stg_byte_r > CHAR_HI) begin
                fail      = 1'b1;
                fail_code = REJ_BAD_CHAR;
              end else begin
                if (stg_byte_r inside {[8'h41:8'h5a]}) begin
                  ch = stg_byte_r[6:0] + 7'h20;
                end else if (stg_byte_r == 8'h5c) begin
                  ch = 7'h2f;
                end
                m0  = res_text(KIND_CHAR, fsel_r, ch, cur_row_r);
                mv0 = 1'b1;
                if (left_r != '0) begin
                  left_nxt = left_r - FLEN_W'(1);
                end
                do_next = (left_nxt == '0);
              end
            end
            PH_TRAILER: begin
              if (sub_r < TRL_OFF_END) begin
                asm_nxt = {asm_r[55:0], stg_byte_r};
              end else if (sub_r < TRL_SIZE_END) begin
                size_nxt = {size_r[23:0], stg_byte_r};
              end else if (sub_r < TRL_STORED_END) begin
                stored_nxt = {stored_r[23:0], stg_byte_r};
              end
              sub_nxt = sub_r + SUB_W'(1);
              if (sub_r >= TRL_FLAG_POS) begin
                if (stg_byte_r > 8'd1) begin
                  fail      = 1'b1;
                  fail_code = REJ_FLAG;
                end else begin
                  m0                 = res_text(KIND_ROW, 2'd0, 7'd0, cur_row_r);
                  m0.row_offset      = asm_r;
                  m0.row_size        = size_r;
                  m0.row_stored_size = stored_r;
                  m0.row_archive     = archive_base + {1'b0, stg_byte_r[0]};
                  mv0                = 1'b1;
                  if (rows_left_r != '0) begin
                    rows_left_nxt = rows_left_r - ROW_W'(1);
                  end
                  cur_row_nxt = cur_row_r + ROW_W'(1);
                  fsel_nxt    = '0;
                  sub_nxt     = '0;
                  asm_nxt     = '0;
                  phase_nxt   = (rows_left_nxt != '0) ? PH_ORDINAL : PH_DONE;
                end
              end
            end
            default: begin
              // bytes past the last row
              fail      = 1'b1;
              fail_code = REJ_LENGTH;
            end
          endcase
        end

        // close the current text field
        if (do_next && !fail) begin
          if (mv0) begin
            m1  = res_text(KIND_FIELD_END, fsel_r, 7'd0, cur_row_r);
            mv1 = 1'b1;
          end else begin
            m0  = res_text(KIND_FIELD_END, fsel_r, 7'd0, cur_row_r);
            mv0 = 1'b1;
          end
          fsel_nxt = fsel_r + 2'd1;
          sub_nxt  = '0;
          asm_nxt  = '0;
          if (fsel_nxt >= FIELD_COUNT) begin
            phase_nxt  = PH_TRAILER;
            size_nxt   = '0;
            stored_nxt = '0;
          end else begin
            phase_nxt = PH_LEN;
          end
        end

        if (fail) begin
          failed_nxt = 1'b1;
          push.v0    = 1'b1;
          push.res0  = res_end(KIND_REJECT, fail_code, stg_eof_r);
        end else if (stg_eof_r) begin
          if (phase_nxt == PH_DONE) begin
            if (({{(32-SEEN_W){1'b0}}, seen_nxt} - LEN_BIAS) == decl_nxt) begin
              fin_res = res_end(KIND_ACCEPT, REJ_MAGIC, 1'b1);
            end else begin
              fin_res = res_end(KIND_REJECT, REJ_LENGTH, 1'b1);
            end
            if (mv0) begin
              push.v0   = 1'b1;
              push.res0 = m0;
              push.v1   = 1'b1;
              push.res1 = fin_res;
            end else begin
              push.v0   = 1'b1;
              push.res0 = fin_res;
            end
          end else begin
            // file ended mid-row: everything else from this byte is dropped
            push.v0   = 1'b1;
            push.res0 = res_end(KIND_REJECT, REJ_TRUNCATED, 1'b1);
          end
        end else begin
          push.v0   = mv0;
          push.res0 = m0;
          push.v1   = mv1;
          push.res1 = m1;
        end
        clear = stg_eof_r;
      end
    end

    if (clear) begin
      phase_nxt     = PH_HEADER;
      sub_nxt       = '0;
      seen_nxt      = '0;
      decl_nxt      = '0;
      rows_left_nxt = '0;
      cur_row_nxt   = '0;
      left_nxt      = '0;
      fsel_nxt      = '0;
      asm_nxt       = '0;
      size_nxt      = '0;
      stored_nxt    = '0;
      failed_nxt    = 1'b0;
    end
  end

endmodule

### src/risp_res_fifo.sv
// Result queue: takes up to two items a cycle, hands out one.
module risp_res_fifo
  import risp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  res_push_t            push,
  input  logic                 pop,
  output res_t                 head,
  output logic                 head_valid,
  output logic [RES_CNT_W-1:0] count
);

  res_t                 slot_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r;
  logic [RES_PTR_W-1:0] rd_ptr_r;
  logic [RES_CNT_W-1:0] cnt_r;
  logic [RES_PTR_W-1:0] wr_ptr_p1;
  logic                 do_pop;

  assign wr_ptr_p1  = wr_ptr_r + RES_PTR_W'(1);
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign count      = cnt_r;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push.v0) begin
      slot_r[wr_ptr_r] <= push.res0;
    end
    if (push.v0 && push.v1) begin
      slot_r[wr_ptr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RES_PTR_W'(push.v0) + RES_PTR_W'(push.v0 && push.v1);
      rd_ptr_r <= rd_ptr_r + RES_PTR_W'(do_pop);
      cnt_r    <= cnt_r + RES_CNT_W'(push.v0) + RES_CNT_W'(push.v0 && push.v1)
                  - RES_CNT_W'(do_pop);
    end
  end

endmodule

### src/resource_index_stream_parser.sv
// Top level of the resource index stream parser: ports, config registers, flow control.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_byte_value[7:0], in_end_of_file
//   out_     output     out_valid/out_ready  kind, field_id, char_value, row_number,
//                                            row_offset, row_size, row_stored_size,
//                                            row_archive, reject_code, final_res
//   cfg_     input      cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[19:0]
//
// One byte per cycle while in_ready is high: a byte is registered, parsed in the following cycle
// and its results (zero, one or two) land in an 8-entry result queue.
// A byte's first result reaches out_ through the byte register and then the result queue.
// A byte that yields two results (char plus field end, row plus final) takes two
// output transfers; the queue absorbs this and in_ready drops only when
// fewer than two slots would be left for the byte in flight and the next one.
// Reset (synchronous, active low) returns the parser to the header and clears the
// config registers; the end-of-file byte rearms the parser without touching config.
module resource_index_stream_parser
  import risp_pkg::*;
#(
  parameter int FIELD_LIMIT = 4096,
  parameter int ROW_LIMIT   = 1000000,
  parameter int FILE_LIMIT  = 67108864
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // byte stream
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte_value,
  input  logic                 in_end_of_file,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_kind,
  output logic [1:0]           out_field_id,
  output logic [6:0]           out_char_value,
  output logic [ROW_W-1:0]     out_row_number,
  output logic [63:0]          out_row_offset,
  output logic [31:0]          out_row_size,
  output logic [31:0]          out_row_stored_size,
  output logic [1:0]           out_row_archive,
  output logic [2:0]           out_reject_code,
  output logic                 out_final_res,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [ROW_W-1:0]     rows_loaded_r;
  logic [1:0]           archive_base_r;
  logic                 in_take;
  logic                 stg_busy;
  res_push_t            push;
  res_t                 head;
  logic [RES_CNT_W-1:0] q_count;
  logic [RES_CNT_W:0]   q_need;

  // config writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_loaded_r  <= '0;
      archive_base_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROWS_LOADED:  rows_loaded_r  <= cfg_data[ROW_W-1:0];
        CFG_ARCHIVE_BASE: archive_base_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // worst case: the byte in the register adds two items, the next byte two more
  assign q_need   = {1'b0, q_count} + (stg_busy ? (RES_CNT_W+1)'(2) : '0);
  assign in_ready = (q_need <= (RES_CNT_W+1)'(RES_DEPTH - 2));
  assign in_take  = in_valid && in_ready;

  risp_parser #(
    .FIELD_LIMIT (FIELD_LIMIT),
    .ROW_LIMIT   (ROW_LIMIT),
    .FILE_LIMIT  (FILE_LIMIT)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (in_take),
    .in_byte      (in_byte_value),
    .in_eof       (in_end_of_file),
    .rows_loaded  (rows_loaded_r),
    .archive_base (archive_base_r),
    .stg_busy     (stg_busy),
    .push         (push)
  );

  risp_res_fifo u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_ready),
    .head       (head),
    .head_valid (out_valid),
    .count      (q_count)
  );

  assign out_kind            = head.kind;
  assign out_field_id        = head.field_id;
  assign out_char_value      = head.char_value;
  assign out_row_number      = head.row_number;
  assign out_row_offset      = head.row_offset;
  assign out_row_size        = head.row_size;
  assign out_row_stored_size = head.row_stored_size;
  assign out_row_archive     = head.row_archive;
  assign out_reject_code     = head.reject_code;
  assign out_final_res       = head.final_res;

endmodule
